// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the set cover rtl
// expects signals named clk and rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define GSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set cover check failed");

// next-cycle implication, checked out of reset
`define GSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set cover check failed");

`endif

// ===== rtl/core/gsc_pkg.sv =====
// types, constants and helpers for the greedy set cover block
// no dependencies; imported by every module of the block
package gsc_pkg;

  // sizing
  localparam int MAX_SETS = 64;
  localparam int ELEMENTS = 64;
  localparam int IDX_W    = $clog2(MAX_SETS);
  localparam int SCNT_W   = $clog2(MAX_SETS + 1);
  localparam int KS_W     = SCNT_W + 1;
  localparam int ECNT_W   = $clog2(ELEMENTS + 1);
  localparam int NGRP     = (ELEMENTS + 7) / 8;

  // fixed field widths
  localparam int SET_W    = 64;
  localparam int SIDX_W   = 6;
  localparam int CNT_W    = 7;
  localparam int GC_W     = 7;
  localparam int ALPHA_W  = 9;
  localparam int TGT_W    = GC_W + ALPHA_W;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [GC_W-1:0]    GC_MAX    = GC_W'(ELEMENTS);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(256);

  // register indexes
  localparam logic [0:0] REG_GROUND = 1'b0;
  localparam logic [0:0] REG_ALPHA  = 1'b1;

  typedef logic [SET_W-1:0]  set_t;
  typedef logic [ECNT_W-1:0] ecnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // control from the sequencer to the head cell
  typedef struct packed {
    logic clear;
    logic sample;
    idx_t idx;
  } scan_ctl_t;

  // best candidate found so far in the current round
  typedef struct packed {
    ecnt_t cnt;
    idx_t  idx;
    set_t  bits;
  } best_t;

  // population count over the element bits, per byte then summed
  function automatic ecnt_t pop_elems(input set_t v);
    logic [3:0] grp [NGRP];
    ecnt_t      sum;
    sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (g * 8 + b < ELEMENTS) begin
          grp[g] = grp[g] + 4'(v[g * 8 + b]);
        end
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      sum = sum + ECNT_W'(grp[g]);
    end
    return sum;
  endfunction

endpackage

// ===== rtl/core/gsc_cell.sv =====
// one link of the set ring: holds a candidate set bitmap
// depends on gsc_pkg
module gsc_cell
  import gsc_pkg::*;
(
  input  logic clk,
  input  logic shift_en,
  input  set_t din,
  output set_t dout
);

  set_t data_r;

  // take the neighbor's set on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= din;
    end
  end

  assign dout = data_r;

endmodule

// ===== rtl/core/gsc_head.sv =====
// head of the ring: counts live members of the passing set and keeps the best
// depends on gsc_pkg
module gsc_head
  import gsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_ctl_t ctl,
  input  set_t      tap,
  input  set_t      live,
  output best_t     best
);

  logic  p_vld_r;
  ecnt_t p_cnt_r;
  idx_t  p_idx_r;
  set_t  p_bits_r;
  best_t best_r;
  set_t  masked;

  assign masked = tap & live;

  // stage one: count remaining members of the set at the tap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= ctl.sample;
    end
  end

  always_ff @(posedge clk) begin
    p_cnt_r  <= pop_elems(masked);
    p_idx_r  <= ctl.idx;
    p_bits_r <= masked;
  end

  // stage two: strictly larger wins, so the lowest index keeps a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (ctl.clear) begin
      best_r <= '0;
    end else if (p_vld_r && (p_cnt_r > best_r.cnt)) begin
      best_r.cnt  <= p_cnt_r;
      best_r.idx  <= p_idx_r;
      best_r.bits <= p_bits_r;
    end
  end

  assign best = best_r;

endmodule

// ===== rtl/core/greedy_set_cover.sv =====
// Set requests are accepted only in the idle state. A solve opens with a start state,
// then each round rotates the whole ring past the head cell once, then passes a
// drain state and a result state that waits while the result register is stalled.
// Rounds number at most ground_count. Synchronous active-low reset clears the
// sequencer, set count, covered map and output valid, and sets ground_count to
// 64 and alpha_q8 to 256; the set cells are not cleared.
`include "assert_macros.svh"

module greedy_set_cover
  import gsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // set requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SET_W-1:0]    in_set_members,
  input  logic                in_last_set,
  // result requests
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SIDX_W-1:0]   out_set_index,
  output logic [SET_W-1:0]    out_new_elements,
  output logic [CNT_W-1:0]    out_new_count,
  output logic [CNT_W-1:0]    out_covered_count,
  output logic                out_last_pick,
  output logic                out_incomplete,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  state_t            state_r, state_nxt;
  idx_t              t_r, t_nxt;
  logic [SCNT_W-1:0] set_count_r, set_count_nxt;
  logic [CNT_W-1:0]  covered_r, covered_nxt;
  set_t              covmap_r, covmap_nxt;
  logic [GC_W-1:0]   ground_count_r;
  logic [ALPHA_W-1:0] alpha_r;

  logic              out_valid_r;
  logic [SIDX_W-1:0] out_set_index_r;
  set_t              out_new_elements_r;
  logic [CNT_W-1:0]  out_new_count_r;
  logic [CNT_W-1:0]  out_covered_count_r;
  logic              out_last_pick_r;
  logic              out_incomplete_r;

  logic              out_load;
  logic [SIDX_W-1:0] res_index;
  set_t              res_bits;
  logic [CNT_W-1:0]  res_count;
  logic [CNT_W-1:0]  res_covered;
  logic              res_last;
  logic              res_incomplete;

  logic              ring_shift, ring_load;
  scan_ctl_t         ctl;
  best_t             best;
  set_t              ring [MAX_SETS];
  set_t              cell0_din;

  logic [GC_W-1:0]    gc_c;
  logic [ALPHA_W-1:0] alpha_c;
  logic [TGT_W-1:0]   target;
  set_t               elem_mask, live;
  logic [CNT_W-1:0]   new_cov;
  logic               new_below;
  logic [KS_W-1:0]    ksum;
  logic               in_acc, cfg_wr, out_free;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_count_r <= GC_MAX;
      alpha_r        <= ALPHA_MAX;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_GROUND: ground_count_r <= pwdata[GC_W-1:0];
        REG_ALPHA:  alpha_r        <= pwdata[ALPHA_W-1:0];
        default:    ground_count_r <= ground_count_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GROUND: prdata = PDATA_W'(ground_count_r);
      REG_ALPHA:  prdata = PDATA_W'(alpha_r);
      default:    prdata = '0;
    endcase
  end

  // clamped problem size, element mask and cover target
  assign gc_c    = (ground_count_r > GC_MAX) ? GC_MAX : ground_count_r;
  assign alpha_c = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : alpha_r;
  assign target  = TGT_W'(alpha_c) * TGT_W'(gc_c);

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      elem_mask[i] = (i < 32'(gc_c));
    end
  end

  assign live = elem_mask & ~covmap_r;

  // coverage after taking the current best
  assign new_cov   = covered_r + CNT_W'(best.cnt);
  assign new_below = TGT_W'({new_cov, 8'h00}) < target;

  // load-order index of the set at the tap this scan cycle, plus MAX_SETS
  assign ksum = KS_W'(t_r) + KS_W'(set_count_r);

  // ring of set cells, tail feeds the head and wraps to the front
  assign cell0_din = ring_load ? in_set_members : ring[MAX_SETS-1];

  for (genvar g = 0; g < MAX_SETS; g++) begin : g_ring
    gsc_cell u_cell (
      .clk      (clk),
      .shift_en (ring_shift),
      .din      ((g == 0) ? cell0_din : ring[(g == 0) ? 0 : g - 1]),
      .dout     (ring[g])
    );
  end

  gsc_head u_head (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .tap   (ring[MAX_SETS-1]),
    .live  (live),
    .best  (best)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      t_r         <= '0;
      set_count_r <= '0;
      covered_r   <= '0;
      covmap_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      t_r         <= t_nxt;
      set_count_r <= set_count_nxt;
      covered_r   <= covered_nxt;
      covmap_r    <= covmap_nxt;
    end
  end

  // next state, ring control and result formation
  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    set_count_nxt  = set_count_r;
    covered_nxt    = covered_r;
    covmap_nxt     = covmap_r;
    ring_shift     = 1'b0;
    ring_load      = 1'b0;
    ctl.clear      = 1'b0;
    ctl.sample     = 1'b0;
    ctl.idx        = IDX_W'(ksum - KS_W'(MAX_SETS));
    out_load       = 1'b0;
    res_index      = '0;
    res_bits       = '0;
    res_count      = '0;
    res_covered    = covered_r;
    res_last       = 1'b1;
    res_incomplete = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (set_count_r < SCNT_W'(MAX_SETS)) begin
            ring_shift    = 1'b1;
            ring_load     = 1'b1;
            set_count_nxt = set_count_r + 1'b1;
          end
          if (in_last_set) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        ctl.clear = 1'b1;
        t_nxt     = '0;
        // target already met: nothing to emit
        if (target == '0) begin
          set_count_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ring_shift = 1'b1;
        ctl.sample = (ksum >= KS_W'(MAX_SETS));
        t_nxt      = t_r + 1'b1;
        if (t_r == IDX_W'(MAX_SETS - 1)) begin
          t_nxt     = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (best.cnt != '0) begin
            res_index      = SIDX_W'(best.idx);
            res_bits       = best.bits;
            res_count      = CNT_W'(best.cnt);
            res_covered    = new_cov;
            res_last       = !new_below;
            res_incomplete = 1'b0;
          end
          if (res_last) begin
            // solve done: the block is empty again
            set_count_nxt = '0;
            covered_nxt   = '0;
            covmap_nxt    = '0;
            state_nxt     = ST_IDLE;
          end else begin
            covered_nxt = new_cov;
            covmap_nxt  = covmap_r | best.bits;
            ctl.clear   = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_set_index_r     <= res_index;
      out_new_elements_r  <= res_bits;
      out_new_count_r     <= res_count;
      out_covered_count_r <= res_covered;
      out_last_pick_r     <= res_last;
      out_incomplete_r    <= res_incomplete;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_set_index     = out_set_index_r;
  assign out_new_elements  = out_new_elements_r;
  assign out_new_count     = out_new_count_r;
  assign out_covered_count = out_covered_count_r;
  assign out_last_pick     = out_last_pick_r;
  assign out_incomplete    = out_incomplete_r;

  // checks
  `GSC_ASSERT_IMP(a_inc_is_last, out_valid_r && out_incomplete_r, out_last_pick_r)
  `GSC_ASSERT_IMP(a_count_matches_bits, out_valid_r,
    CNT_W'(pop_elems(out_new_elements_r)) == out_new_count_r)
  `GSC_ASSERT_NXT(a_clear_after_last, out_load && res_last,
    (set_count_r == '0) && (covered_r == '0) && (covmap_r == '0))
  `GSC_ASSERT_IMP(a_map_stable_in_scan, (state_r == ST_SCAN) || (state_r == ST_DRAIN),
    $countones(covmap_r) == 32'(covered_r))

endmodule

// ===== dv/tb_greedy_set_cover.sv =====
// testbench for greedy_set_cover: loads candidate sets, checks every greedy pick
// against an in-bench greedy cover predictor; depends on gsc_pkg types
module tb_greedy_set_cover
  import gsc_pkg::*;
;

  localparam int ITEM_TOTAL = 410;
  localparam int CALM_ITEMS = 60;
  // one solve start plus a couple of full ring rotations
  localparam int SOLVE_TAIL = 2 * (MAX_SETS + 2) + 4;
  localparam int MAX_PRINTS = 50;

  typedef struct {
    logic [SIDX_W-1:0] idx;
    set_t              bits;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  cov;
    logic              last;
    logic              inc;
  } cover_pick_t;

  // greedy cover predictor and store of expected picks
  class cover_scoreboard;
    set_t              loaded_sets[$];
    logic [GC_W-1:0]    ground_cfg = GC_MAX;
    logic [ALPHA_W-1:0] alpha_cfg  = ALPHA_MAX;
    cover_pick_t       expected_picks[$];
    int                errors = 0;

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    // one greedy solve over the loaded sets, then the problem is empty again
    function void solve_cover();
      int unsigned gc;
      int unsigned alpha;
      int unsigned covered;
      int unsigned best;
      int unsigned best_cnt;
      int unsigned c;
      int          rounds;
      set_t        mask;
      set_t        taken;
      set_t        pick;
      cover_pick_t p;
      gc       = ground_cfg;
      alpha    = alpha_cfg;
      covered  = 0;
      rounds   = 0;
      taken    = '0;
      if (gc > ELEMENTS) gc = ELEMENTS;
      if (alpha > 256) alpha = 256;
      mask = (gc >= 64) ? '1 : ((64'd1 << gc) - 64'd1);
      while (covered * 256 < alpha * gc && rounds < 64) begin
        best     = 0;
        best_cnt = 0;
        foreach (loaded_sets[i]) begin
          c = $countones(loaded_sets[i] & mask & ~taken);
          if (c > best_cnt) begin
            best_cnt = c;
            best     = i;
          end
        end
        // no set adds anything: flag and stop
        if (best_cnt == 0) begin
          p = '{idx: '0, bits: '0, cnt: '0, cov: CNT_W'(covered), last: 1'b1, inc: 1'b1};
          expected_picks.insert(expected_picks.size(), p);
          break;
        end
        pick = loaded_sets[best] & mask & ~taken;
        foreach (loaded_sets[i]) loaded_sets[i] &= ~pick;
        taken   |= pick;
        covered += best_cnt;
        p.idx  = SIDX_W'(best);
        p.bits = pick;
        p.cnt  = CNT_W'(best_cnt);
        p.cov  = CNT_W'(covered);
        p.last = (covered * 256 < alpha * gc) ? 1'b0 : 1'b1;
        p.inc  = 1'b0;
        expected_picks.insert(expected_picks.size(), p);
        rounds++;
      end
      loaded_sets.delete();
    endfunction

    // accepted set request
    function void note_set(set_t members, logic last);
      if (loaded_sets.size() < MAX_SETS) loaded_sets.insert(loaded_sets.size(), members);
      if (last) solve_cover();
    endfunction

    // accepted result request
    task check_pick(cover_pick_t got);
      cover_pick_t want;
      if (expected_picks.size() == 0) begin
        report($sformatf("unexpected result, set_index %0d", got.idx));
        return;
      end
      want = expected_picks.pop_front();
      if (got.idx !== want.idx)
        report($sformatf("set_index got %0d want %0d", got.idx, want.idx));
      if (got.bits !== want.bits)
        report($sformatf("new_elements got %h want %h", got.bits, want.bits));
      if (got.cnt !== want.cnt)
        report($sformatf("new_count got %0d want %0d", got.cnt, want.cnt));
      if (got.cov !== want.cov)
        report($sformatf("covered_count got %0d want %0d", got.cov, want.cov));
      if (got.last !== want.last)
        report($sformatf("last_pick got %b want %b", got.last, want.last));
      if (got.inc !== want.inc)
        report($sformatf("incomplete got %b want %b", got.inc, want.inc));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SET_W-1:0]    in_set_members;
  logic                in_last_set;
  logic                out_valid;
  logic                out_ready;
  logic [SIDX_W-1:0]   out_set_index;
  logic [SET_W-1:0]    out_new_elements;
  logic [CNT_W-1:0]    out_new_count;
  logic [CNT_W-1:0]    out_covered_count;
  logic                out_last_pick;
  logic                out_incomplete;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  cover_scoreboard sb = new();
  int              items_sent = 0;
  bit              calm = 1'b0;

  greedy_set_cover u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_set_members    (in_set_members),
    .in_last_set       (in_last_set),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_set_index     (out_set_index),
    .out_new_elements  (out_new_elements),
    .out_new_count     (out_new_count),
    .out_covered_count (out_covered_count),
    .out_last_pick     (out_last_pick),
    .out_incomplete    (out_incomplete),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // accepted set requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_set(in_set_members, in_last_set);
  end

  // accepted result requests are checked
  always @(posedge clk) begin
    cover_pick_t got;
    if (rst_n && out_valid && out_ready) begin
      got.idx  = out_set_index;
      got.bits = out_new_elements;
      got.cnt  = out_new_count;
      got.cov  = out_covered_count;
      got.last = out_last_pick;
      got.inc  = out_incomplete;
      sb.check_pick(got);
    end
  end

  // result side back-pressure in bursts, none once calm
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // register write, then read back
  task automatic write_reg(input logic [0:0] reg_idx, input logic [PDATA_W-1:0] value);
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_idx == REG_GROUND) sb.ground_cfg = value[GC_W-1:0];
    else sb.alpha_cfg = value[ALPHA_W-1:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) sb.report($sformatf("readback reg %0d got %h want %h",
                                              reg_idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for every expected pick, optionally let a silent solve finish too
  // the first edge lets the predictor see a request accepted at the current one
  task automatic drain(input bit with_tail);
    @(posedge clk);
    while (sb.expected_picks.size() != 0) @(posedge clk);
    if (with_tail) repeat (SOLVE_TAIL) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned gc, input int unsigned alpha);
    drain(1'b1);
    write_reg(REG_GROUND, PDATA_W'(gc));
    write_reg(REG_ALPHA, PDATA_W'(alpha));
  endtask

  // one problem: every set in order, the final one marked last
  task automatic send_problem(input set_t members[$]);
    foreach (members[k]) begin
      in_valid       <= 1'b1;
      in_set_members <= members[k];
      in_last_set    <= (k == members.size() - 1);
      do @(posedge clk); while (!in_ready);
      items_sent++;
      if (!calm && k < members.size() - 1 && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // random set with a spread of densities
  function automatic set_t random_members(input int unsigned gc);
    set_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: v &= {$urandom, $urandom};
      1: v &= {$urandom, $urandom} & {$urandom, $urandom};
      2: v |= {$urandom, $urandom};
      3: v = 64'd1 << $urandom_range(0, 63);
      4: if (gc < 64) v &= (64'd1 << gc) - 64'd1;
      5: if ($urandom_range(0, 3) == 0) v = '0;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    set_t        prob[$];
    int unsigned gc;
    int unsigned alpha;
    int unsigned n_sets;
    int          prob_no;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_set_members <= '0;
    in_last_set    <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: full ground, full cover
    send_problem('{'1});
    // tie on the first pick, then picks until no set adds anything
    send_problem('{64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FF00,
                   64'h0000_0000_00FF_0000, 64'h0000_0000_0000_000F});
    send_problem('{64'h0});
    send_problem('{64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE});
    // narrow ground, alpha above full cover, members out of range
    set_config(8, 511);
    send_problem('{64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0000_0000_00F0,
                   64'hFFFF_FFFF_FFFF_FF0F});
    // target already met: no picks
    set_config(0, 256);
    send_problem('{'1});
    set_config(100, 0);
    send_problem('{'1});
    // oversized ground count with the smallest nonzero alpha
    set_config(127, 1);
    send_problem('{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
    set_config(1, 256);
    send_problem('{64'h2, 64'h3});

    // random problems, config changed every few
    prob_no = 0;
    while (items_sent < ITEM_TOTAL) begin
      calm = (items_sent >= ITEM_TOTAL - CALM_ITEMS);
      if (prob_no % 6 == 0) begin
        case ($urandom_range(0, 8))
          0: gc = 1;
          1: gc = 2;
          2: gc = 64;
          3: gc = 127;
          4: gc = $urandom_range(65, 127);
          5: gc = 0;
          default: gc = $urandom_range(3, 63);
        endcase
        case ($urandom_range(0, 7))
          0: alpha = 0;
          1: alpha = 1;
          2: alpha = 256;
          3: alpha = 511;
          4: alpha = $urandom_range(257, 511);
          default: alpha = $urandom_range(2, 255);
        endcase
        if (prob_no == 12) gc = 64;
        set_config(gc, alpha);
      end
      // sender holds off until the previous solve is fully out
      if (prob_no % 7 == 3) drain(1'b0);
      if (prob_no == 12) n_sets = MAX_SETS + 2;
      else if ($urandom_range(0, 6) == 0) n_sets = $urandom_range(9, 20);
      else n_sets = $urandom_range(1, 8);
      prob.delete();
      repeat (n_sets) prob.insert(prob.size(), random_members(gc));
      send_problem(prob);
      if (!calm && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) @(posedge clk);
      prob_no++;
    end

    drain(1'b1);
    if (sb.expected_picks.size() != 0)
      sb.report($sformatf("%0d picks never came", sb.expected_picks.size()));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
